### src/afd_pkg.sv
package afd_pkg;

  localparam int MAX_CHANNELS = 64;

  localparam int CH_W     = 6;
  localparam int POS_W    = 4;
  localparam int BYTE_W   = 8;
  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 8;
  localparam int PROD_W   = SAMPLE_W + COEF_W;
  localparam int ACC_W    = PROD_W + 1;
  localparam int PRED_SH  = 6;
  localparam int PRED_W   = ACC_W - PRED_SH;
  localparam int SUM_W    = PRED_W + 1;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;

  // history store depth follows the channel count, capped by the channel field
  localparam int HIST_DEPTH = (MAX_CHANNELS < (1 << CH_W)) ? MAX_CHANNELS : (1 << CH_W);
  localparam int HIST_AW    = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;

  localparam logic [POS_W-1:0] POS_HEADER     = 4'd0;
  localparam logic [POS_W-1:0] POS_FLAGS      = 4'd1;
  localparam logic [POS_W-1:0] POS_LAST_DATA  = 4'd15;
  localparam logic [2:0]       MAX_FILTER     = 3'd4;
  localparam logic signed [ACC_W-1:0] ROUND_BIAS = 25'sd32;
  localparam logic signed [SUM_W-1:0] SAT_MAX    = 20'sd32767;
  localparam logic signed [SUM_W-1:0] SAT_MIN    = -20'sd32768;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL0,
    ST_MUL1,
    ST_SUM,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_MUL,
    OP_MAC,
    OP_FIN
  } mac_op_t;

  typedef struct packed {
    logic    ready;
    logic    load_hist;
    mac_op_t op;
    logic    out_valid;
    logic    half;
    logic    advance;
    logic    finish;
  } ctrl_t;

  function automatic logic signed [COEF_W-1:0] coef_recent(input logic [2:0] f);
    logic signed [COEF_W-1:0] c;
    case (f)
      3'd0:    c = 8'sd0;
      3'd1:    c = 8'sd60;
      3'd2:    c = 8'sd115;
      3'd3:    c = 8'sd98;
      default: c = 8'sd122;
    endcase
    return c;
  endfunction

  function automatic logic signed [COEF_W-1:0] coef_older(input logic [2:0] f);
    logic signed [COEF_W-1:0] c;
    case (f)
      3'd0:    c = 8'sd0;
      3'd1:    c = 8'sd0;
      3'd2:    c = -8'sd52;
      3'd3:    c = -8'sd55;
      default: c = -8'sd60;
    endcase
    return c;
  endfunction

endpackage

### src/afd_ram.sv
module afd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/afd_mac.sv
module afd_mac (
  input  logic                                 clk,
  input  afd_pkg::mac_op_t                     op,
  input  logic signed [afd_pkg::SAMPLE_W-1:0]  a,
  input  logic signed [afd_pkg::COEF_W-1:0]    coef,
  input  logic signed [afd_pkg::SAMPLE_W-1:0]  base,
  output logic signed [afd_pkg::SAMPLE_W-1:0]  result
);

  logic signed [afd_pkg::PROD_W-1:0] prod;
  logic signed [afd_pkg::ACC_W-1:0]  acc;
  logic signed [afd_pkg::ACC_W-1:0]  rnd;
  logic signed [afd_pkg::PRED_W-1:0] pred;
  logic signed [afd_pkg::SUM_W-1:0]  sum;
  logic signed [afd_pkg::SAMPLE_W-1:0] sat;

  assign prod = a * coef;
  assign rnd  = acc + afd_pkg::ROUND_BIAS;
  assign pred = afd_pkg::PRED_W'(rnd >>> afd_pkg::PRED_SH);
  assign sum  = afd_pkg::SUM_W'(base) + afd_pkg::SUM_W'(pred);

  always_comb begin
    if (sum > afd_pkg::SAT_MAX) begin
      sat = afd_pkg::SAMPLE_W'(afd_pkg::SAT_MAX);
    end else if (sum < afd_pkg::SAT_MIN) begin
      sat = afd_pkg::SAMPLE_W'(afd_pkg::SAT_MIN);
    end else begin
      sat = afd_pkg::SAMPLE_W'(sum);
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      afd_pkg::OP_MUL: acc <= afd_pkg::ACC_W'(prod);
      afd_pkg::OP_MAC: acc <= acc + afd_pkg::ACC_W'(prod);
      afd_pkg::OP_FIN: result <= sat;
      default: ;
    endcase
  end

endmodule

### src/afd_ctrl.sv
module afd_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_is_data,
  input  logic           out_ready,
  output afd_pkg::ctrl_t ctl
);

  afd_pkg::state_t state;
  afd_pkg::state_t state_next;
  logic            half;

  always_comb begin
    state_next = state;
    case (state)
      afd_pkg::ST_IDLE: if (in_valid && in_is_data) state_next = afd_pkg::ST_READ;
      afd_pkg::ST_READ: state_next = afd_pkg::ST_MUL0;
      afd_pkg::ST_MUL0: state_next = afd_pkg::ST_MUL1;
      afd_pkg::ST_MUL1: state_next = afd_pkg::ST_SUM;
      afd_pkg::ST_SUM:  state_next = afd_pkg::ST_OUT;
      afd_pkg::ST_OUT: begin
        if (out_ready) begin
          state_next = half ? afd_pkg::ST_IDLE : afd_pkg::ST_MUL0;
        end
      end
      default: state_next = afd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl           = '0;
    ctl.op        = afd_pkg::OP_NONE;
    ctl.half      = half;
    case (state)
      afd_pkg::ST_IDLE: ctl.ready = 1'b1;
      afd_pkg::ST_READ: ctl.load_hist = 1'b1;
      afd_pkg::ST_MUL0: ctl.op = afd_pkg::OP_MUL;
      afd_pkg::ST_MUL1: ctl.op = afd_pkg::OP_MAC;
      afd_pkg::ST_SUM:  ctl.op = afd_pkg::OP_FIN;
      afd_pkg::ST_OUT: begin
        ctl.out_valid = 1'b1;
        ctl.advance   = out_ready && !half;
        ctl.finish    = out_ready && half;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= afd_pkg::ST_IDLE;
      half  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == afd_pkg::ST_READ) begin
        half <= 1'b0;
      end else if (ctl.advance) begin
        half <= 1'b1;
      end
    end
  end

endmodule

### src/adpcm_frame_decoder.sv
// data byte: the first sample is offered after the states read, mul0, mul1 and sum;
// the second one after mul0, mul1 and sum again once the first is taken; the next
// request is taken the cycle after that; both samples use the single shared mac
// header and flags bytes keep the controller idle and produce no sample
// reset clears filter, shift and per-channel history valid bits at once, so
// every channel reads zero history; no clearing pass
module adpcm_frame_decoder (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // channel[5:0], byte_position[9:6], frame_byte[17:10], zero[23:18]
  input  logic [afd_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // out_channel[5:0], pcm_sample[21:6], zero[23:22]
  output logic [afd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  output logic                               m_axis_tlast
);

  logic [afd_pkg::CH_W-1:0]    in_ch;
  logic [afd_pkg::POS_W-1:0]   in_pos;
  logic [afd_pkg::BYTE_W-1:0]  in_byte;
  logic                        in_ch_ok;
  logic                        in_is_data;
  logic                        accept;

  logic [afd_pkg::CH_W-1:0]    ch_reg;
  logic [afd_pkg::POS_W-1:0]   pos_reg;
  logic [afd_pkg::BYTE_W-1:0]  byte_reg;
  logic [2:0]                  filter_index;
  logic [3:0]                  shift_amount;
  logic [afd_pkg::HIST_DEPTH-1:0] hist_valid;

  logic signed [afd_pkg::SAMPLE_W-1:0] prev1;
  logic signed [afd_pkg::SAMPLE_W-1:0] prev2;
  logic signed [afd_pkg::SAMPLE_W-1:0] sample;
  logic signed [afd_pkg::SAMPLE_W-1:0] mac_a;
  logic signed [afd_pkg::COEF_W-1:0]   mac_coef;
  logic signed [afd_pkg::SAMPLE_W-1:0] base;
  logic [3:0]                          nib;

  logic [2*afd_pkg::SAMPLE_W-1:0] rd_word;
  logic [2*afd_pkg::SAMPLE_W-1:0] wr_word;

  afd_pkg::ctrl_t ctl;

  assign in_ch      = s_axis_tdata[5:0];
  assign in_pos     = s_axis_tdata[9:6];
  assign in_byte    = s_axis_tdata[17:10];
  assign in_ch_ok   = int'(in_ch) < afd_pkg::MAX_CHANNELS;
  assign in_is_data = in_ch_ok && (in_pos != afd_pkg::POS_HEADER) &&
                      (in_pos != afd_pkg::POS_FLAGS);
  assign accept     = s_axis_tvalid && s_axis_tready;

  afd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_is_data(in_is_data),
    .out_ready (m_axis_tready),
    .ctl       (ctl)
  );

  // history word: recent sample in the low half, older in the high half
  assign wr_word = {prev1, sample};

  afd_ram #(
    .WIDTH(2 * afd_pkg::SAMPLE_W),
    .DEPTH(afd_pkg::HIST_DEPTH)
  ) u_hist (
    .clk  (clk),
    .we   (ctl.finish),
    .waddr(ch_reg[afd_pkg::HIST_AW-1:0]),
    .wdata(wr_word),
    .raddr(in_ch[afd_pkg::HIST_AW-1:0]),
    .rdata(rd_word)
  );

  assign nib  = ctl.half ? byte_reg[7:4] : byte_reg[3:0];
  assign base = $signed({nib, 12'h000}) >>> shift_amount;

  assign mac_a    = (ctl.op == afd_pkg::OP_MAC) ? prev2 : prev1;
  assign mac_coef = (ctl.op == afd_pkg::OP_MAC) ? afd_pkg::coef_older(filter_index)
                                                : afd_pkg::coef_recent(filter_index);

  afd_mac u_mac (
    .clk   (clk),
    .op    (ctl.op),
    .a     (mac_a),
    .coef  (mac_coef),
    .base  (base),
    .result(sample)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_index <= '0;
      shift_amount <= '0;
      hist_valid   <= '0;
    end else begin
      if (accept && in_ch_ok && in_pos == afd_pkg::POS_HEADER) begin
        filter_index <= (in_byte[7:4] > 4'(afd_pkg::MAX_FILTER)) ? afd_pkg::MAX_FILTER
                                                                : in_byte[6:4];
        shift_amount <= in_byte[3:0];
      end
      if (ctl.finish) begin
        hist_valid[ch_reg[afd_pkg::HIST_AW-1:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ch_reg   <= in_ch;
      pos_reg  <= in_pos;
      byte_reg <= in_byte;
    end
    if (ctl.load_hist) begin
      // never-written channels read as zero history
      if (hist_valid[ch_reg[afd_pkg::HIST_AW-1:0]]) begin
        prev1 <= rd_word[afd_pkg::SAMPLE_W-1:0];
        prev2 <= rd_word[2*afd_pkg::SAMPLE_W-1:afd_pkg::SAMPLE_W];
      end else begin
        prev1 <= '0;
        prev2 <= '0;
      end
    end else if (ctl.advance) begin
      prev2 <= prev1;
      prev1 <= sample;
    end
  end

  assign s_axis_tready = ctl.ready;
  assign m_axis_tvalid = ctl.out_valid;
  assign m_axis_tdata  = {2'b00, sample, ch_reg};
  assign m_axis_tlast  = ctl.half && (pos_reg == afd_pkg::POS_LAST_DATA);

endmodule

### src/afd_checker.sv
module afd_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic [afd_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [afd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                            m_axis_tlast
);

  logic data_req;
  logic ctl_req;

  assign data_req = s_axis_tvalid && s_axis_tready &&
                    (s_axis_tdata[9:6] != afd_pkg::POS_HEADER) &&
                    (s_axis_tdata[9:6] != afd_pkg::POS_FLAGS) &&
                    (int'(s_axis_tdata[5:0]) < afd_pkg::MAX_CHANNELS);
  assign ctl_req  = s_axis_tvalid && s_axis_tready && !data_req;

  // one item at a time: never taking a request while a sample is offered
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("request taken while sample pending");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    data_req |=> !s_axis_tready)
    else $error("ready right after data byte");

  a_hdr: assert property (@(posedge clk) disable iff (rst)
    ctl_req |=> s_axis_tready)
    else $error("header or flags byte stalled the input");

  a_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready)
    else $error("not ready after last sample of frame");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled sample changed");

endmodule

bind adpcm_frame_decoder afd_checker u_afd_checker (.*);

### tb/sv/adpcm_frame_decoder_checker.sv
module adpcm_frame_decoder_checker
  import afd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_ready,
  // channel[5:0], byte_position[9:6], frame_byte[17:10], zero[23:18]
  input  logic [IN_TDATA_W-1:0]  in_data,
  input  logic                   out_valid,
  input  logic                   out_ready,
  // out_channel[5:0], pcm_sample[21:6], zero[23:22]
  input  logic [OUT_TDATA_W-1:0] out_data,
  input  logic                   out_last,
  output int                     mismatches,
  output int                     pending_samples
);

  localparam int PCM_MAX       = 32767;
  localparam int PCM_MIN       = -32768;
  localparam int NIBBLE_SCALE  = 4096;
  localparam int ROUND_HALF    = 32;
  localparam int MAX_PRINTED   = 100;

  typedef struct {
    logic [CH_W-1:0]            channel;
    logic signed [SAMPLE_W-1:0] pcm;
    logic                       frame_done;
  } pcm_sample_t;

  pcm_sample_t pcm_expected[$];

  logic signed [SAMPLE_W-1:0] newest_pcm [HIST_DEPTH];
  logic signed [SAMPLE_W-1:0] prior_pcm  [HIST_DEPTH];
  logic [2:0]                 cur_filter;
  logic [3:0]                 cur_shift;

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_PRINTED)
      $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // one nibble through scale, shift and two-tap prediction, then saturation
  function automatic logic signed [SAMPLE_W-1:0] decode_nibble(
    input logic [3:0]                 nib,
    input logic signed [SAMPLE_W-1:0] newer,
    input logic signed [SAMPLE_W-1:0] elder
  );
    int nib_val;
    int p1;
    int p2;
    int c0;
    int c1;
    int scaled;
    int pred;
    int total;
    nib_val = int'($signed(nib));
    p1 = int'(newer);
    p2 = int'(elder);
    case (cur_filter)
      3'd0: begin c0 = 0;   c1 = 0;   end
      3'd1: begin c0 = 60;  c1 = 0;   end
      3'd2: begin c0 = 115; c1 = -52; end
      3'd3: begin c0 = 98;  c1 = -55; end
      default: begin c0 = 122; c1 = -60; end
    endcase
    scaled = (nib_val * NIBBLE_SCALE) >>> cur_shift;
    pred   = (p1 * c0 + p2 * c1 + ROUND_HALF) >>> PRED_SH;
    total  = scaled + pred;
    if (total > PCM_MAX) total = PCM_MAX;
    if (total < PCM_MIN) total = PCM_MIN;
    return total[SAMPLE_W-1:0];
  endfunction

  task automatic decode_request(
    input logic [CH_W-1:0]   ch,
    input logic [POS_W-1:0]  pos,
    input logic [BYTE_W-1:0] raw
  );
    logic signed [SAMPLE_W-1:0] first;
    logic signed [SAMPLE_W-1:0] second;
    pcm_sample_t                item;
    if (ch < MAX_CHANNELS) begin
      if (pos == POS_HEADER) begin
        cur_filter = (raw[7:4] > MAX_FILTER) ? MAX_FILTER : raw[6:4];
        cur_shift  = raw[3:0];
      end else if (pos != POS_FLAGS) begin
        first  = decode_nibble(raw[3:0], newest_pcm[ch], prior_pcm[ch]);
        second = decode_nibble(raw[7:4], first, newest_pcm[ch]);
        prior_pcm[ch]  = first;
        newest_pcm[ch] = second;
        item.channel    = ch;
        item.pcm        = first;
        item.frame_done = 1'b0;
        pcm_expected.push_back(item);
        item.pcm        = second;
        item.frame_done = (pos == POS_LAST_DATA);
        pcm_expected.push_back(item);
      end
    end
  endtask

  task automatic check_sample(
    input logic [CH_W-1:0]            got_ch,
    input logic signed [SAMPLE_W-1:0] got_pcm,
    input logic                       got_last
  );
    pcm_sample_t want;
    if (pcm_expected.size() == 0) begin
      report_mismatch($sformatf("sample ch %0d pcm %0d with none expected",
                                got_ch, got_pcm));
    end else begin
      want = pcm_expected.pop_front();
      if (got_ch !== want.channel)
        report_mismatch($sformatf("channel got %0d expected %0d", got_ch, want.channel));
      if (got_pcm !== want.pcm)
        report_mismatch($sformatf("ch %0d pcm got %0d expected %0d",
                                  want.channel, got_pcm, want.pcm));
      if (got_last !== want.frame_done)
        report_mismatch($sformatf("ch %0d frame_done got %b expected %b",
                                  want.channel, got_last, want.frame_done));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HIST_DEPTH; i++) begin
        newest_pcm[i] = '0;
        prior_pcm[i]  = '0;
      end
      cur_filter = '0;
      cur_shift  = '0;
      mismatches = 0;
      pcm_expected.delete();
    end else begin
      // results first: a sample leaving now belongs to an earlier request
      if (out_valid && out_ready)
        check_sample(out_data[CH_W-1:0], $signed(out_data[CH_W +: SAMPLE_W]), out_last);
      if (in_valid && in_ready)
        decode_request(in_data[CH_W-1:0], in_data[CH_W +: POS_W],
                       in_data[CH_W+POS_W +: BYTE_W]);
    end
    pending_samples = pcm_expected.size();
  end

endmodule

### tb/sv/adpcm_frame_decoder_tb.sv
module adpcm_frame_decoder_tb;
  import afd_pkg::*;

  localparam int RANDOM_ITEMS = 750;
  localparam int QUIET_TAIL   = 100;
  localparam int HOLD_CYCLES  = 80;
  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 30;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;

  int mismatches;
  int pending_samples;
  int sent_bytes;
  int hold_requests;
  int quiet_cycles;
  bit gaps_on;

  always #6 clk = ~clk;

  adpcm_frame_decoder dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  adpcm_frame_decoder_checker pcm_check (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (s_axis_tvalid),
    .in_ready        (s_axis_tready),
    .in_data         (s_axis_tdata),
    .out_valid       (m_axis_tvalid),
    .out_ready       (m_axis_tready),
    .out_data        (m_axis_tdata),
    .out_last        (m_axis_tlast),
    .mismatches      (mismatches),
    .pending_samples (pending_samples)
  );

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // sample sink: random stall bursts, plus long hold-offs on request
  initial begin
    int holds_served;
    holds_served  = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != holds_served) begin
        holds_served++;
        m_axis_tready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (gaps_on && !rst && $urandom_range(0, 4) == 0) begin
        m_axis_tready = 1'b0;
        repeat ($urandom_range(1, 6) - 1) @(negedge clk);
      end else begin
        m_axis_tready = !rst;
      end
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic put_byte(
    input logic [CH_W-1:0]   ch,
    input logic [POS_W-1:0]  pos,
    input logic [BYTE_W-1:0] raw
  );
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = '0;
    s_axis_tdata[CH_W-1:0]             = ch;
    s_axis_tdata[CH_W +: POS_W]        = pos;
    s_axis_tdata[CH_W+POS_W +: BYTE_W] = raw;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
    sent_bytes++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid = 1'b0;
    while (pending_samples != 0) @(negedge clk);
  endtask

  // header, flags, then data; some frames are cut short
  task automatic send_frame(input logic [CH_W-1:0] ch);
    logic [3:0] filt;
    logic [3:0] shamt;
    int         len;
    filt  = 4'(($urandom_range(0, 9) < 8) ? $urandom_range(0, 4) : $urandom_range(5, 15));
    shamt = 4'(($urandom_range(0, 5) == 0) ? $urandom_range(13, 15) : $urandom_range(0, 12));
    len   = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 15) : 16;
    put_byte(ch, POS_HEADER, {filt, shamt});
    for (int p = 1; p < len; p++)
      put_byte(ch, p[POS_W-1:0], 8'($urandom_range(0, 255)));
  endtask

  initial begin
    int frame_no;
    int noise_len;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    sent_bytes    = 0;
    hold_requests = 0;
    gaps_on       = 1'b1;
    repeat (3) @(negedge clk);
    rst = 1'b0;

    // data before any header uses filter 0, shift 0
    put_byte(6'd0, 4'd2, 8'h7F);
    put_byte(6'd0, POS_HEADER, 8'h00);
    put_byte(6'd0, POS_FLAGS, 8'hFF);
    put_byte(6'd0, 4'd2, 8'h88);
    put_byte(6'd0, 4'd3, 8'h77);
    // filter 4 with no shift drives the history into saturation
    put_byte(6'd63, POS_HEADER, 8'h40);
    put_byte(6'd63, 4'd2, 8'h77);
    put_byte(6'd63, 4'd3, 8'h77);
    put_byte(6'd63, 4'd4, 8'h77);
    put_byte(6'd63, 4'd5, 8'h88);
    // filter nibble above 4 is capped
    put_byte(6'd63, POS_HEADER, 8'hF0);
    put_byte(6'd63, 4'd6, 8'h88);
    put_byte(6'd5, POS_HEADER, 8'h5D);
    put_byte(6'd5, 4'd7, 8'h8F);
    put_byte(6'd5, POS_HEADER, 8'h3F);
    put_byte(6'd5, POS_LAST_DATA, 8'h80);
    put_byte(6'd42, POS_HEADER, 8'h2E);
    put_byte(6'd42, 4'd14, 8'hA5);
    put_byte(6'd42, POS_LAST_DATA, 8'h5A);
    put_byte(6'd21, POS_HEADER, 8'h1C);
    put_byte(6'd21, 4'd8, 8'hFF);
    // header state is shared: channel 0 decodes with channel 21's header
    put_byte(6'd0, POS_LAST_DATA, 8'h00);
    put_byte(6'd63, POS_FLAGS, 8'h00);
    put_byte(6'd63, POS_LAST_DATA, 8'h88);

    sent_bytes = 0;
    frame_no   = 0;
    while (sent_bytes < RANDOM_ITEMS) begin
      gaps_on = (sent_bytes < RANDOM_ITEMS - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
      if (frame_no == 10 || frame_no == 33)
        hold_requests++;
      if (frame_no == 22)
        wait_drained();
      if ($urandom_range(0, 9) < 8) begin
        send_frame(6'($urandom_range(0, 63)));
      end else begin
        noise_len = $urandom_range(1, 8);
        repeat (noise_len)
          put_byte(6'($urandom_range(0, 63)), 4'($urandom_range(0, 15)),
                   8'($urandom_range(0, 255)));
      end
      frame_no++;
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && pending_samples == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
